// File: rtl/sync_header_packet_deframer_macros.svh
// Assertion macros shared by the sync-header packet deframer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SYNC_HEADER_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_HEADER_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shpd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shpd: next-cycle check failed");

`endif

// File: rtl/shpd_pkg.sv
// Package for the sync-header packet deframer: constants and the result type.
// Used by shpd_in_reg, shpd_core and the top level; depends on nothing.
package shpd_pkg;

  localparam int SyncRunLen = 3;
  localparam int HeaderLen  = 10;
  localparam int MaxPacket  = 2048;
  localparam int IdxW       = 11;
  localparam int InDataW    = 8;
  localparam int OutDataW   = 40;

  localparam logic [7:0] SyncByte = 8'h11;

  typedef struct packed {
    logic            aborted;
    logic [7:0]      payload_byte;
    logic [IdxW-1:0] payload_index;
    logic [7:0]      packet_tag;
    logic [7:0]      header_checksum;
    logic            last;
  } result_t;

endpackage

// File: rtl/shpd_in_reg.sv
// Input register stage of the sync-header packet deframer.
// Holds one received byte until the core consumes it; uses shpd_pkg.
module shpd_in_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [shpd_pkg::InDataW-1:0]    in_tdata,
  input  logic                            pop,
  output logic                            byte_valid,
  output logic [7:0]                      byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  // The stage refills in the same cycle that the core drains it.
  assign in_tready = !valid_r || pop;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata[7:0];
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

// File: rtl/shpd_core.sv
// Deframing state and result register of the sync-header packet deframer.
// Uses shpd_pkg and the assertion macros header.
`include "sync_header_packet_deframer_macros.svh"

module shpd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output shpd_pkg::result_t res_data
);

  localparam logic [1:0]  RunLen   = 2'(shpd_pkg::SyncRunLen);
  localparam logic [3:0]  HdrLen   = 4'(shpd_pkg::HeaderLen);
  localparam logic [3:0]  TagPos   = HdrLen - 4'd2;
  localparam logic [3:0]  CsumPos  = HdrLen - 4'd1;
  localparam logic signed [31:0] MaxPkt = 32'(shpd_pkg::MaxPacket);
  localparam logic [31:0] LastOfs  = 32'(shpd_pkg::HeaderLen + 1);
  localparam logic [shpd_pkg::IdxW-1:0] IdxMax = '1;
  localparam logic [shpd_pkg::IdxW-1:0] IdxOne = shpd_pkg::IdxW'(1);

  logic [1:0]                   sync_run_r, sync_run_nxt;
  logic                         loading_r, loading_nxt;
  logic [3:0]                   header_count_r, header_count_nxt;
  logic signed [31:0]           length_limit_r, length_limit_nxt;
  logic [7:0]                   tag_r, tag_nxt;
  logic [7:0]                   csum_r, csum_nxt;
  logic [shpd_pkg::IdxW-1:0]    payload_count_r, payload_count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  shpd_pkg::result_t            out_data_r, out_data_nxt;
  logic [7:0]                   hdr_store_r [8];
  logic signed [31:0]           size_r;

  logic [1:0]         run_inc;
  logic               start;
  logic               in_header;
  logic               has_result;
  logic               fire;
  logic               is_last;
  logic signed [31:0] size_word;
  logic signed [31:0] size_clamp;
  logic signed [31:0] len_word;

  assign run_inc    = (byte_data != shpd_pkg::SyncByte) ? 2'd0 :
                      (sync_run_r == 2'd3) ? 2'd3 : sync_run_r + 2'd1;
  assign start      = (run_inc == RunLen);
  assign in_header  = (header_count_r != HdrLen);
  assign has_result = loading_r && (start || !in_header);
  // Bytes that give no result never wait for the result register.
  assign fire       = byte_valid && (!has_result || !out_valid_r || res_ready);
  assign pop        = fire;

  assign size_word  = {hdr_store_r[3], hdr_store_r[2], hdr_store_r[1], hdr_store_r[0]};
  assign size_clamp = (size_word > MaxPkt) ? MaxPkt : size_word;
  assign len_word   = {hdr_store_r[7], hdr_store_r[6], hdr_store_r[5], hdr_store_r[4]};
  assign is_last    = ((32'(payload_count_r) + LastOfs) == length_limit_r);

  always_comb begin
    sync_run_nxt      = sync_run_r;
    loading_nxt       = loading_r;
    header_count_nxt  = header_count_r;
    length_limit_nxt  = length_limit_r;
    tag_nxt           = tag_r;
    csum_nxt          = csum_r;
    payload_count_nxt = payload_count_r;
    out_data_nxt      = out_data_r;
    out_valid_nxt     = out_valid_r && !res_ready;

    if (fire) begin
      if (start) begin
        sync_run_nxt     = 2'd0;
        loading_nxt      = 1'b1;
        header_count_nxt = 4'd0;
        if (loading_r) begin
          out_data_nxt         = '0;
          out_data_nxt.aborted = 1'b1;
          out_valid_nxt        = 1'b1;
        end
      end else begin
        sync_run_nxt = run_inc;
        if (loading_r && in_header) begin
          header_count_nxt = header_count_r + 4'd1;
          if (header_count_r == TagPos) begin
            tag_nxt = byte_data;
          end else if (header_count_r == CsumPos) begin
            csum_nxt          = byte_data;
            length_limit_nxt  = (len_word > size_r) ? size_r : len_word;
            payload_count_nxt = '0;
          end
        end else if (loading_r) begin
          out_data_nxt.aborted         = 1'b0;
          out_data_nxt.payload_byte    = byte_data;
          out_data_nxt.payload_index   = payload_count_r;
          out_data_nxt.packet_tag      = tag_r;
          out_data_nxt.header_checksum = csum_r;
          out_data_nxt.last            = is_last;
          out_valid_nxt                = 1'b1;
          if (is_last) begin
            loading_nxt       = 1'b0;
            payload_count_nxt = '0;
          end else if (payload_count_r != IdxMax) begin
            payload_count_nxt = payload_count_r + IdxOne;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_run_r      <= '0;
      loading_r       <= 1'b0;
      header_count_r  <= '0;
      length_limit_r  <= '0;
      tag_r           <= '0;
      csum_r          <= '0;
      payload_count_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      sync_run_r      <= sync_run_nxt;
      loading_r       <= loading_nxt;
      header_count_r  <= header_count_nxt;
      length_limit_r  <= length_limit_nxt;
      tag_r           <= tag_nxt;
      csum_r          <= csum_nxt;
      payload_count_r <= payload_count_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Header bytes and the clamped size are always written before they are read.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (fire && !start && loading_r && in_header) begin
      if (!header_count_r[3]) begin
        hdr_store_r[header_count_r[2:0]] <= byte_data;
      end
      if (header_count_r == TagPos) begin
        size_r <= size_clamp;
      end
    end
  end

  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

  `SHPD_ASSERT_IMPLY(a_hdr_count_range, clk, rst_n, 1'b1, header_count_r <= HdrLen)
  `SHPD_ASSERT_IMPLY(a_abort_zero_fields, clk, rst_n, out_valid_r && out_data_r.aborted,
    (out_data_r.payload_byte == 8'd0) && (out_data_r.payload_index == '0) && !out_data_r.last)
  `SHPD_ASSERT_NEXT(a_start_restarts, clk, rst_n, fire && start,
    loading_r && (header_count_r == 4'd0) && (sync_run_r == 2'd0))
  `SHPD_ASSERT_NEXT(a_last_ends_packet, clk, rst_n, fire && has_result && !start && is_last,
    !loading_r && (payload_count_r == '0))
  `SHPD_ASSERT_IMPLY(a_no_result_overwrite, clk, rst_n, fire && has_result,
    !out_valid_r || res_ready)

endmodule

// File: rtl/sync_header_packet_deframer.sv
// Top level of the sync-header packet deframer: stream ports, input stage, core.
// Depends on shpd_pkg, shpd_in_reg and shpd_core.
//
//   channel | direction | tdata                     | tuser   | tlast
//   in_     | slave     | rx_byte                   | -       | -
//   out_    | master    | payload/index/tag/csum    | aborted | last
//
// One byte per clock is sustained unless a result waits on a stalled output;
// a transferred byte is loaded into the input register and then into the
// deframing state and the result register.
// Reset is synchronous and active low and clears all control state.
// A stalled output holds only bytes that produce a result; header bytes and sync
// bytes that do not complete a run inside a packet keep flowing while a result waits.
module sync_header_packet_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [shpd_pkg::InDataW-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] payload_byte, [18:8] payload_index, [26:19] packet_tag,
  // [34:27] header_checksum, [39:35] zero
  output logic [shpd_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tuser,  // [0] aborted
  output logic                          out_tlast
);

  logic              pop;
  logic              byte_valid;
  logic [7:0]        byte_data;
  shpd_pkg::result_t res;

  shpd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  shpd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_data   (res)
  );

  assign out_tdata = {5'd0, res.header_checksum, res.packet_tag, res.payload_index,
                      res.payload_byte};
  assign out_tuser = res.aborted;
  assign out_tlast = res.last;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for sync_header_packet_deframer: byte stream in, payload results out.
// Predicts every result with its own deframing model and checks each out_ transfer in order.
// Depends on shpd_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;

  localparam int ClkHalf     = 2;
  localparam int ResetCycles = 12;
  localparam int RandomItems = 800;
  localparam int TailItems   = 150;  // no idling once this few bytes remain
  localparam int DrainCycles = 20;
  localparam int IndexMax    = 2047;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [shpd_pkg::InDataW-1:0]  in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [shpd_pkg::OutDataW-1:0] out_tdata;
  logic                          out_tuser;
  logic                          out_tlast;

  logic [7:0]        rx_bytes_queue[$];
  shpd_pkg::result_t expected_results[$];
  int                total_bytes = 0;
  int                bytes_accepted = 0;
  int                mismatch_count = 0;
  int                gap_hold = 0;
  int                ready_hold = 0;
  shpd_pkg::result_t want;

  // Deframer state as the block should hold it.
  logic [1:0]  sync_seen;
  bit          in_packet;
  logic [3:0]  header_seen;
  logic [7:0]  header_bytes[8];
  int          length_bound;
  logic [7:0]  tag_byte;
  logic [7:0]  csum_byte;
  logic [10:0] payload_seen;

  sync_header_packet_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #ClkHalf clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_v);
    if (got !== exp_v) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_v));
    end
  endtask

  function automatic int header_word(input int base);
    return $signed({header_bytes[base+3], header_bytes[base+2],
                    header_bytes[base+1], header_bytes[base]});
  endfunction

  // Advances the expected state by one received byte and queues any result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    shpd_pkg::result_t r;
    int                size_w;
    int                len_w;
    bit                is_last;
    r = '0;
    if (b == shpd_pkg::SyncByte) begin
      if (sync_seen < 2'd3) sync_seen++;
    end else begin
      sync_seen = 2'd0;
    end
    if (sync_seen == shpd_pkg::SyncRunLen) begin
      // A completed sync run inside a packet throws it away.
      if (in_packet) begin
        r.aborted = 1'b1;
        expected_results.push_back(r);
      end
      in_packet   = 1'b1;
      header_seen = '0;
      sync_seen   = 2'd0;
    end else if (in_packet) begin
      if (header_seen < shpd_pkg::HeaderLen) begin
        if (header_seen < 8) header_bytes[header_seen[2:0]] = b;
        else if (header_seen == 8) tag_byte = b;
        else csum_byte = b;
        header_seen++;
        if (header_seen == shpd_pkg::HeaderLen) begin
          size_w = header_word(0);
          len_w  = header_word(4);
          if (size_w > shpd_pkg::MaxPacket) size_w = shpd_pkg::MaxPacket;
          if (len_w > size_w) len_w = size_w;
          length_bound = len_w;
          payload_seen = '0;
        end
      end else begin
        is_last = (int'(payload_seen) + 1 + shpd_pkg::HeaderLen) == length_bound;
        r.payload_byte    = b;
        r.payload_index   = payload_seen;
        r.packet_tag      = tag_byte;
        r.header_checksum = csum_byte;
        r.last            = is_last;
        expected_results.push_back(r);
        if (is_last) begin
          in_packet    = 1'b0;
          payload_seen = '0;
        end else if (payload_seen < IndexMax) begin
          payload_seen++;
        end
      end
    end
  endtask

  // Input side: a byte stays on the bus until it is taken, gaps come in short bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_hold  <= 0;
    end else if (in_tvalid && !in_tready) begin
      // Hold the current byte.
    end else if (gap_hold != 0) begin
      in_tvalid <= 1'b0;
      gap_hold  <= gap_hold - 1;
    end else if (rx_bytes_queue.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (rx_bytes_queue.size() > TailItems && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      gap_hold  <= $urandom_range(0, 2);
    end else begin
      in_tvalid <= 1'b1;
      in_tdata  <= rx_bytes_queue.pop_front();
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (rx_bytes_queue.size() > TailItems && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_seen    = '0;
      in_packet    = 1'b0;
      header_seen  = '0;
      length_bound = 0;
      tag_byte     = '0;
      csum_byte    = '0;
      payload_seen = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with none expected, tdata 0x%0h",
                                    out_tdata));
        end else begin
          want = expected_results.pop_front();
          check_field("aborted", out_tuser, want.aborted);
          check_field("payload_byte", out_tdata[7:0], want.payload_byte);
          check_field("payload_index", out_tdata[18:8], want.payload_index);
          check_field("packet_tag", out_tdata[26:19], want.packet_tag);
          check_field("header_checksum", out_tdata[34:27], want.header_checksum);
          check_field("tdata padding", out_tdata[39:35], 32'd0);
          check_field("last", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        bytes_accepted++;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_bytes_queue.push_back(b);
  endtask

  task automatic push_word(input logic [31:0] w);
    push_byte(w[7:0]);
    push_byte(w[15:8]);
    push_byte(w[23:16]);
    push_byte(w[31:24]);
  endtask

  task automatic push_sync();
    repeat (shpd_pkg::SyncRunLen) push_byte(shpd_pkg::SyncByte);
  endtask

  function automatic logic [7:0] random_byte();
    // Sync bytes show up more often than chance so that short runs occur in data.
    if ($urandom_range(0, 15) == 0) return shpd_pkg::SyncByte;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_packet(input int size_w, input int len_w, input int nbytes);
    push_sync();
    push_word(size_w);
    push_word(len_w);
    push_byte(random_byte());
    push_byte(random_byte());
    repeat (nbytes) push_byte(random_byte());
  endtask

  initial begin
    int pick;
    int size_w;
    int len_w;
    int eff_len;
    int nbytes;
    int round;

    // Directed: idle bytes at both extremes, then a packet whose size is clamped.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_sync();
    push_word(32'h7FFFFFFF);
    push_word(32'd13);
    push_byte(shpd_pkg::SyncByte);  // tag and checksum are sync bytes that do not complete a run
    push_byte(shpd_pkg::SyncByte);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(shpd_pkg::SyncByte);  // last payload byte, which also starts a new run
    push_byte(shpd_pkg::SyncByte);
    push_byte(shpd_pkg::SyncByte);  // completes the run: a new packet starts
    push_sync();                    // restart while loading the header: abort

    round = 0;
    while (rx_bytes_queue.size() < RandomItems) begin
      round++;
      pick = $urandom_range(0, 9);
      if (round == 12) begin
        // Short length: no payload byte is ever last, so the packet runs on.
        push_packet(shpd_pkg::MaxPacket, 5, 40);
      end else if (pick < 8) begin
        pick = $urandom_range(0, 9);
        len_w = $urandom_range(11, 40);
        if (pick < 2) size_w = shpd_pkg::MaxPacket;
        else if (pick < 4) size_w = $urandom_range(shpd_pkg::MaxPacket + 1, 32'h7FFFFFFF);
        else if (pick < 5) size_w = 32'h80000000 | $urandom();
        else size_w = len_w + $urandom_range(0, 20);
        pick = $urandom_range(0, 9);
        if (pick == 0) len_w = $urandom_range(0, shpd_pkg::HeaderLen);
        else if (pick == 1) len_w = 32'h80000000 | $urandom();
        else if (pick == 2 && size_w <= 40) len_w = $urandom_range(size_w + 1, 32'h7FFFFFFF);
        eff_len = (size_w > shpd_pkg::MaxPacket) ? shpd_pkg::MaxPacket : size_w;
        if (len_w < eff_len) eff_len = len_w;
        if (eff_len > shpd_pkg::HeaderLen) nbytes = eff_len - shpd_pkg::HeaderLen;
        else nbytes = $urandom_range(1, 20);
        // Now and then a packet is cut short by the next sync run.
        if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes);
        push_packet(size_w, len_w, nbytes);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) push_byte(random_byte());
        end
      end else if (pick == 8) begin
        // Incomplete sync run followed by noise.
        push_byte(shpd_pkg::SyncByte);
        push_byte(shpd_pkg::SyncByte);
        repeat ($urandom_range(1, 6)) push_byte(random_byte());
      end else begin
        // Header broken off by a new sync run.
        push_sync();
        repeat ($urandom_range(1, shpd_pkg::HeaderLen - 1)) push_byte(random_byte());
      end
    end
    push_sync();
    total_bytes = rx_bytes_queue.size();

    while (bytes_accepted < total_bytes) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
  end

endmodule
